// ----- src/bchs_pkg.sv -----
// shared types, codes and constants of the charger handshake controller
`default_nettype none

package bchs_pkg;

    // item kinds
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_STEP  = 2'd2;

    // received frame codes
    localparam logic [3:0] MSG_CODE1 = 4'd0;
    localparam logic [3:0] MSG_BUI   = 4'd1;
    localparam logic [3:0] MSG_BCS   = 4'd2;
    localparam logic [3:0] MSG_BFD   = 4'd3;
    localparam logic [3:0] MSG_BHM   = 4'd4;
    localparam logic [3:0] MSG_BRM   = 4'd5;
    localparam logic [3:0] MSG_BCP   = 4'd6;
    localparam logic [3:0] MSG_BRO   = 4'd7;
    localparam logic [3:0] MSG_BCL   = 4'd8;
    localparam logic [3:0] MSG_BST   = 4'd9;

    // sent frame codes
    localparam logic [2:0] FC_CBV = 3'd0;
    localparam logic [2:0] FC_CHM = 3'd1;
    localparam logic [2:0] FC_CRM = 3'd2;
    localparam logic [2:0] FC_CML = 3'd3;
    localparam logic [2:0] FC_CRO = 3'd4;
    localparam logic [2:0] FC_CCS = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_RETRY     = 2'd1;
    localparam logic [1:0] CFG_HS_RETRY  = 2'd2;

    localparam logic [11:0] TIMEOUT_RESET  = 12'd2000;
    localparam logic [5:0]  RETRY_RESET    = 6'd10;
    localparam logic [5:0]  HS_RETRY_RESET = 6'd50;

    localparam logic [11:0] SILENCE_MAX   = 12'hFFF;
    localparam logic [7:0]  CODE_BYTE_MAX = 8'd127;
    localparam logic [7:0]  LEVEL_FULL    = 8'd100;
    localparam logic [7:0]  READY_BYTE    = 8'hAA;

    localparam logic [63:0] DATA_ACK  = 64'hFFFF_FFFF_FFFF_FFAA;
    localparam logic [63:0] DATA_CML  = 64'h0000_3E08_12C0_1770;
    localparam logic [63:0] DATA_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // event flag bits
    localparam int FL_HANDSHAKE = 0;
    localparam int FL_IDENT     = 1;
    localparam int FL_PARAM     = 2;
    localparam int FL_READY     = 3;
    localparam int FL_DEMAND    = 4;
    localparam int FL_STATUS    = 5;
    localparam int FL_STOP      = 6;

    localparam int DESC_DEPTH = 4;

    typedef enum logic [12:0] {
        ST_INIT      = 13'b0000000000001,
        ST_CHECK     = 13'b0000000000010,
        ST_HANDSHAKE = 13'b0000000000100,
        ST_WAIT_HS   = 13'b0000000001000,
        ST_IDENT     = 13'b0000000010000,
        ST_WAIT_ID   = 13'b0000000100000,
        ST_MAX_OUT   = 13'b0000001000000,
        ST_WAIT_MAX  = 13'b0000010000000,
        ST_READY     = 13'b0000100000000,
        ST_WAIT_RDY  = 13'b0001000000000,
        ST_CHARGING  = 13'b0010000000000,
        ST_STOP      = 13'b0100000000000,
        ST_FINISH    = 13'b1000000000000
    } seq_t;

    // frame group that one step sends
    typedef enum logic [2:0] {
        PAT_NONE = 3'd0,
        PAT_CHM  = 3'd1,
        PAT_CRM  = 3'd2,
        PAT_CML  = 3'd3,
        PAT_CRO  = 3'd4,
        PAT_CHG  = 3'd5,
        PAT_CBV  = 3'd6
    } pat_t;

    typedef struct packed {
        pat_t       pat;
        logic       connected;
        logic [3:0] charge_state;
    } desc_t;

    typedef struct packed {
        logic [11:0] timeout_ms;
        logic [5:0]  retry_limit;
        logic [5:0]  handshake_retry_limit;
    } cfg_t;

endpackage

`default_nettype wire

// ----- src/bchs_front.sv -----
// front part: takes items, keeps link state, runs the sequence and queues step descriptors
`default_nettype none

module bchs_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic [1:0]        kind,
    input  wire logic [3:0]        msg_code,
    input  wire logic [63:0]       payload,
    input  wire bchs_pkg::cfg_t    cfg,
    output logic                   desc_push,
    output bchs_pkg::desc_t        desc
);

    bchs_pkg::seq_t seq_reg, seq_next;
    logic [5:0]  retry_reg, retry_next;
    logic [11:0] silence_reg, silence_next;
    logic [7:0]  level_reg, level_next;
    logic [7:0]  code_byte_reg, code_byte_next;
    logic [31:0] err_reg, err_next;
    logic [6:0]  flags_reg, flags_next;
    logic        conn_reg, conn_next;

    // values seen by the sequence after the silence check
    logic        expired;
    logic [7:0]  lvl_e, cb_e;
    logic [31:0] err_e;
    logic [6:0]  fl_e;
    logic        conn_e;
    logic [6:0]  retry_inc;
    bchs_pkg::pat_t pat;

    function automatic logic [3:0] state_code(input bchs_pkg::seq_t s);
        case (s)
            bchs_pkg::ST_INIT:      state_code = 4'd0;
            bchs_pkg::ST_CHECK:     state_code = 4'd1;
            bchs_pkg::ST_HANDSHAKE: state_code = 4'd2;
            bchs_pkg::ST_WAIT_HS:   state_code = 4'd3;
            bchs_pkg::ST_IDENT:     state_code = 4'd4;
            bchs_pkg::ST_WAIT_ID:   state_code = 4'd5;
            bchs_pkg::ST_MAX_OUT:   state_code = 4'd6;
            bchs_pkg::ST_WAIT_MAX:  state_code = 4'd7;
            bchs_pkg::ST_READY:     state_code = 4'd8;
            bchs_pkg::ST_WAIT_RDY:  state_code = 4'd9;
            bchs_pkg::ST_CHARGING:  state_code = 4'd10;
            bchs_pkg::ST_STOP:      state_code = 4'd11;
            bchs_pkg::ST_FINISH:    state_code = 4'd12;
            default:                state_code = 4'd0;
        endcase
    endfunction

    always_comb
    begin
        seq_next       = seq_reg;
        retry_next     = retry_reg;
        silence_next   = silence_reg;
        level_next     = level_reg;
        code_byte_next = code_byte_reg;
        err_next       = err_reg;
        flags_next     = flags_reg;
        conn_next      = conn_reg;
        pat            = bchs_pkg::PAT_NONE;
        desc_push      = 1'b0;

        expired   = silence_reg > cfg.timeout_ms;
        lvl_e     = expired ? 8'd0 : level_reg;
        cb_e      = expired ? 8'd0 : code_byte_reg;
        err_e     = expired ? 32'd0 : err_reg;
        fl_e      = expired ? 7'd0 : flags_reg;
        conn_e    = expired ? 1'b0 : conn_reg;
        retry_inc = {1'b0, retry_reg} + 7'd1;

        if (take)
        begin
            case (kind)
                bchs_pkg::KIND_FRAME:
                begin
                    silence_next = 12'd0;
                    case (msg_code)
                        bchs_pkg::MSG_CODE1:
                            code_byte_next = (payload[7:0] > bchs_pkg::CODE_BYTE_MAX)
                                             ? 8'd0 : payload[7:0];
                        bchs_pkg::MSG_BUI: level_next = payload[7:0];
                        bchs_pkg::MSG_BCS:
                        begin
                            flags_next[bchs_pkg::FL_STATUS] = 1'b1;
                            level_next = payload[39:32];
                        end
                        bchs_pkg::MSG_BFD: err_next = payload[31:0];
                        bchs_pkg::MSG_BHM: flags_next[bchs_pkg::FL_HANDSHAKE] = 1'b1;
                        bchs_pkg::MSG_BRM: flags_next[bchs_pkg::FL_IDENT] = 1'b1;
                        bchs_pkg::MSG_BCP: flags_next[bchs_pkg::FL_PARAM] = 1'b1;
                        bchs_pkg::MSG_BRO:
                            if (payload[7:0] == bchs_pkg::READY_BYTE)
                                flags_next[bchs_pkg::FL_READY] = 1'b1;
                        bchs_pkg::MSG_BCL: flags_next[bchs_pkg::FL_DEMAND] = 1'b1;
                        bchs_pkg::MSG_BST: flags_next[bchs_pkg::FL_STOP] = 1'b1;
                        default: ;
                    endcase
                end
                bchs_pkg::KIND_TICK:
                begin
                    if (silence_reg != bchs_pkg::SILENCE_MAX)
                        silence_next = silence_reg + 12'd1;
                end
                bchs_pkg::KIND_STEP:
                begin
                    desc_push      = 1'b1;
                    silence_next   = expired ? 12'd0 : silence_reg;
                    level_next     = lvl_e;
                    code_byte_next = cb_e;
                    err_next       = err_e;
                    flags_next     = fl_e;
                    conn_next      = conn_e;
                    case (seq_reg)
                        bchs_pkg::ST_CHECK:
                        begin
                            if (cb_e != 8'd0 && lvl_e < bchs_pkg::LEVEL_FULL)
                            begin
                                conn_next  = 1'b1;
                                seq_next   = (err_e != 32'd0) ? bchs_pkg::ST_INIT
                                                              : bchs_pkg::ST_HANDSHAKE;
                                retry_next = 6'd0;
                            end
                            else if (lvl_e == bchs_pkg::LEVEL_FULL)
                            begin
                                conn_next = 1'b1;
                                seq_next  = bchs_pkg::ST_FINISH;
                            end
                            else
                            begin
                                seq_next = bchs_pkg::ST_INIT;
                                if (retry_inc > {1'b0, cfg.retry_limit})
                                begin
                                    retry_next = cfg.retry_limit;
                                    conn_next  = 1'b0;
                                end
                                else
                                    retry_next = retry_inc[5:0];
                            end
                        end
                        bchs_pkg::ST_HANDSHAKE:
                        begin
                            pat      = bchs_pkg::PAT_CHM;
                            seq_next = bchs_pkg::ST_WAIT_HS;
                        end
                        bchs_pkg::ST_WAIT_HS:
                        begin
                            if (fl_e[bchs_pkg::FL_HANDSHAKE])
                                seq_next = bchs_pkg::ST_IDENT;
                            else if (retry_inc > {1'b0, cfg.handshake_retry_limit})
                            begin
                                retry_next = 6'd0;
                                seq_next   = bchs_pkg::ST_INIT;
                            end
                            else
                            begin
                                retry_next = retry_inc[5:0];
                                seq_next   = bchs_pkg::ST_HANDSHAKE;
                            end
                        end
                        bchs_pkg::ST_IDENT:
                        begin
                            pat      = bchs_pkg::PAT_CRM;
                            seq_next = bchs_pkg::ST_WAIT_ID;
                        end
                        bchs_pkg::ST_WAIT_ID:
                        begin
                            if (fl_e[bchs_pkg::FL_IDENT] && fl_e[bchs_pkg::FL_PARAM])
                                seq_next = bchs_pkg::ST_MAX_OUT;
                            else if (retry_inc > {1'b0, cfg.retry_limit})
                            begin
                                retry_next = 6'd0;
                                seq_next   = bchs_pkg::ST_INIT;
                            end
                            else
                            begin
                                retry_next = retry_inc[5:0];
                                seq_next   = bchs_pkg::ST_IDENT;
                            end
                        end
                        bchs_pkg::ST_MAX_OUT:
                        begin
                            pat      = bchs_pkg::PAT_CML;
                            seq_next = bchs_pkg::ST_WAIT_MAX;
                        end
                        bchs_pkg::ST_WAIT_MAX:
                        begin
                            if (fl_e[bchs_pkg::FL_READY])
                                seq_next = bchs_pkg::ST_READY;
                            else if (retry_inc > {1'b0, cfg.retry_limit})
                            begin
                                retry_next = 6'd0;
                                seq_next   = bchs_pkg::ST_INIT;
                            end
                            else
                            begin
                                retry_next = retry_inc[5:0];
                                seq_next   = bchs_pkg::ST_MAX_OUT;
                            end
                        end
                        bchs_pkg::ST_READY:
                        begin
                            pat      = bchs_pkg::PAT_CRO;
                            seq_next = bchs_pkg::ST_WAIT_RDY;
                        end
                        bchs_pkg::ST_WAIT_RDY:
                        begin
                            if (fl_e[bchs_pkg::FL_STOP])
                                seq_next = bchs_pkg::ST_INIT;
                            else if (fl_e[bchs_pkg::FL_DEMAND] && fl_e[bchs_pkg::FL_STATUS])
                                seq_next = bchs_pkg::ST_CHARGING;
                        end
                        bchs_pkg::ST_CHARGING:
                        begin
                            pat      = bchs_pkg::PAT_CHG;
                            seq_next = fl_e[bchs_pkg::FL_STOP] ? bchs_pkg::ST_STOP
                                                               : bchs_pkg::ST_WAIT_RDY;
                        end
                        bchs_pkg::ST_STOP:
                            seq_next = bchs_pkg::ST_FINISH;
                        default:
                        begin
                            // init and finish both announce the charger and go to check
                            pat      = bchs_pkg::PAT_CBV;
                            seq_next = bchs_pkg::ST_CHECK;
                        end
                    endcase
                    // the silence check sends the sequence home before it runs;
                    // the retry count survives it
                    if (expired && seq_reg != bchs_pkg::ST_INIT)
                    begin
                        pat        = bchs_pkg::PAT_CBV;
                        seq_next   = bchs_pkg::ST_CHECK;
                        conn_next  = 1'b0;
                        retry_next = retry_reg;
                    end
                end
                default: ;
            endcase
        end

        desc.pat          = pat;
        desc.connected    = conn_next;
        desc.charge_state = state_code(seq_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= bchs_pkg::ST_INIT;
            retry_reg     <= 6'd0;
            silence_reg   <= 12'd0;
            level_reg     <= 8'd0;
            code_byte_reg <= 8'd0;
            err_reg       <= 32'd0;
            flags_reg     <= 7'd0;
            conn_reg      <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            retry_reg     <= retry_next;
            silence_reg   <= silence_next;
            level_reg     <= level_next;
            code_byte_reg <= code_byte_next;
            err_reg       <= err_next;
            flags_reg     <= flags_next;
            conn_reg      <= conn_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/bchs_dq.sv -----
// short descriptor queue between the front and back parts
`default_nettype none

module bchs_dq #(
    parameter int DEPTH = bchs_pkg::DESC_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bchs_pkg::desc_t   wr_data,
    output logic                   full,
    input  wire logic              pop,
    output bchs_pkg::desc_t        rd_data,
    output logic                   empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    bchs_pkg::desc_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic do_push, do_pop;

    assign full    = count_reg == CNT_FULL;
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

`default_nettype wire

// ----- src/bchs_back.sv -----
// back part: expands one step descriptor into its frames, one item per cycle while pop is held
`default_nettype none

module bchs_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bchs_pkg::desc_t   q_data,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output logic                   empty,
    input  wire logic              pop,
    output logic                   send_valid,
    output logic [2:0]             frame_code,
    output logic [63:0]            frame_data,
    output logic                   last,
    output logic                   connected,
    output logic [3:0]             charge_state
);

    logic            cur_valid_reg, cur_valid_next;
    bchs_pkg::desc_t cur_reg, cur_next;
    logic [2:0]      idx_reg, idx_next;
    logic            advance, load;

    function automatic logic [2:0] pat_count(input bchs_pkg::pat_t p);
        case (p)
            bchs_pkg::PAT_CRM: pat_count = 3'd2;
            bchs_pkg::PAT_CHG: pat_count = 3'd5;
            default:           pat_count = 3'd1;
        endcase
    endfunction

    always_comb
    begin
        send_valid = 1'b1;
        frame_data = 64'd0;
        case (cur_reg.pat)
            bchs_pkg::PAT_CHM: frame_code = bchs_pkg::FC_CHM;
            bchs_pkg::PAT_CRM:
            begin
                frame_code = bchs_pkg::FC_CRM;
                frame_data = bchs_pkg::DATA_ACK;
            end
            bchs_pkg::PAT_CML:
            begin
                frame_code = bchs_pkg::FC_CML;
                frame_data = bchs_pkg::DATA_CML;
            end
            bchs_pkg::PAT_CRO:
            begin
                frame_code = bchs_pkg::FC_CRO;
                frame_data = bchs_pkg::DATA_ACK;
            end
            bchs_pkg::PAT_CHG:
                // ccs, ccs, cbv, ccs, cbv
                frame_code = (idx_reg == 3'd2 || idx_reg == 3'd4) ? bchs_pkg::FC_CBV
                                                                  : bchs_pkg::FC_CCS;
            bchs_pkg::PAT_CBV:
            begin
                frame_code = bchs_pkg::FC_CBV;
                frame_data = bchs_pkg::DATA_ONES;
            end
            default:
            begin
                frame_code = bchs_pkg::FC_CBV;
                send_valid = 1'b0;
            end
        endcase
    end

    assign last         = idx_reg == pat_count(cur_reg.pat) - 3'd1;
    assign connected    = cur_reg.connected;
    assign charge_state = cur_reg.charge_state;
    assign empty        = !cur_valid_reg;
    assign advance      = pop && cur_valid_reg;
    assign load         = (!cur_valid_reg || (advance && last)) && !q_empty;
    assign q_pop        = load;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            cur_valid_next = 1'b1;
            cur_next       = q_data;
            idx_next       = 3'd0;
        end
        else if (advance && last)
            cur_valid_next = 1'b0;
        else if (advance)
            idx_next = idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

`default_nettype wire

// ----- src/battery_charge_handshake_fsm.sv -----
// top level of the charger-side handshake controller
//
// channel   direction  handshake              payload
// input     in         push / full            kind, msg_code, payload
// result    out        empty / pop            send_valid, frame_code, frame_data,
//                                             last, connected, charge_state
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// the front takes one item per cycle while full is low; a step item is resolved
// in its accept cycle. results leave one per cycle while pop is held: a step
// sends 1, 2 or 5 items, so the back part sets the sustained rate of steps
// full rises only when the descriptor queue (DESC_DEPTH steps) is full
// rst_n clears all link state and the queues at once; no clearing pass
`default_nettype none

module battery_charge_handshake_fsm #(
    parameter int DESC_DEPTH = bchs_pkg::DESC_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input item channel
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  kind,
    input  wire logic [3:0]  msg_code,
    input  wire logic [63:0] payload,
    // result channel
    output logic             empty,
    input  wire logic        pop,
    output logic             send_valid,
    output logic [2:0]       frame_code,
    output logic [63:0]      frame_data,
    output logic             last,
    output logic             connected,
    output logic [3:0]       charge_state,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    bchs_pkg::cfg_t  cfg_reg;
    bchs_pkg::desc_t front_desc, q_data;
    logic            front_push, take;
    logic            q_pop, q_empty;

    // ready always; user keeps block idle on register writes; block does not check
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms            <= bchs_pkg::TIMEOUT_RESET;
            cfg_reg.retry_limit           <= bchs_pkg::RETRY_RESET;
            cfg_reg.handshake_retry_limit <= bchs_pkg::HS_RETRY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bchs_pkg::CFG_TIMEOUT:  cfg_reg.timeout_ms <= cfg_data;
                bchs_pkg::CFG_RETRY:    cfg_reg.retry_limit <= cfg_data[5:0];
                bchs_pkg::CFG_HS_RETRY: cfg_reg.handshake_retry_limit <= cfg_data[5:0];
                default: ;   // unused index, write dropped
            endcase
        end
    end

    // an item is taken whenever the queue has room, whatever its kind
    assign take = push && !full;

    bchs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .kind      (kind),
        .msg_code  (msg_code),
        .payload   (payload),
        .cfg       (cfg_reg),
        .desc_push (front_push),
        .desc      (front_desc)
    );

    // steps waiting for the back part to send their frames
    bchs_dq #(
        .DEPTH (DESC_DEPTH)
    ) u_dq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .wr_data (front_desc),
        .full    (full),
        .pop     (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    bchs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_data),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .send_valid   (send_valid),
        .frame_code   (frame_code),
        .frame_data   (frame_data),
        .last         (last),
        .connected    (connected),
        .charge_state (charge_state)
    );

`ifndef SYNTHESIS
    // a step with no frame is a single closing item
    a_idle_step_single: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !send_valid |-> last && frame_code == bchs_pkg::FC_CBV)
        else $error("frameless step item not marked last");

    // the items of one step follow each other without a gap
    a_step_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !last |=> !empty)
        else $error("step items interrupted");

    // sequence state reported stays within the thirteen states
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> charge_state <= 4'd12)
        else $error("charge_state out of range");

    // state and link flag hold across the items of one step
    a_step_fields_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !last |=> $stable(charge_state) && $stable(connected))
        else $error("step fields changed within a step");
`endif

endmodule

`default_nettype wire
